/* hw/rtl/time_ordered_event_priority_queue_unit_macros.svh */
// Assertion helpers used by the queue datapath RTL
`ifndef TIME_ORDERED_EVENT_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TIME_ORDERED_EVENT_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Clocked check, masked while reset is high
`define TOEPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define TOEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/toepq_pkg.sv */
package toepq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int TIME_W   = 32;
   localparam int ID_W     = 16;
   localparam int HANDLE_W = 16;
   localparam int KEY_W    = TIME_W + ID_W;
   localparam int COUNT_W  = 5;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_code_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // take the request word
      logic rd_prev;   // read the entry just below the walk slot
      logic rd_head;   // read the front entry
      logic shift_wr;  // move the read entry up into the walk slot
      logic ins_wr;    // write the new entry into the walk slot
      logic pop;       // retire the front entry and post it
      logic rsp_load;  // post a response with no entry
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_deq;
      logic count_zero;
      logic full;
      logic at_head;
      logic key_ge;
      logic rsp_free;
   } dp_stat_type;

endpackage

/* hw/rtl/toepq_ctrl.sv */
module toepq_ctrl
   import toepq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CMP,
      S_DEQ_RD,
      S_DEQ_OUT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (stat.req_deq) begin
                  state_in = stat.count_zero ? S_FINISH : S_DEQ_RD;
               end else begin
                  state_in = stat.full ? S_FINISH : S_WALK_RD;
               end
            end
         end
         S_WALK_RD: begin
            if (stat.at_head) begin
               cmd.ins_wr = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            // equal keys move up too, so the new word lands ahead of them
            if (stat.key_ge) begin
               cmd.shift_wr = 1'b1;
               state_in     = S_WALK_RD;
            end else begin
               cmd.ins_wr = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_DEQ_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = S_DEQ_OUT;
         end
         S_DEQ_OUT: begin
            if (stat.rsp_free) begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/toepq_datapath.sv */
module toepq_datapath
   import toepq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_op,
   input  logic [TIME_W-1:0]   req_time,
   input  logic [ID_W-1:0]     req_id,
   input  logic [HANDLE_W-1:0] req_handle,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [1:0]          rsp_status,
   output logic                rsp_out_valid,
   output logic [TIME_W-1:0]   rsp_time,
   output logic [ID_W-1:0]     rsp_id,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic                rsp_empty,
   output logic [COUNT_W-1:0]  rsp_count
);

`include "time_ordered_event_priority_queue_unit_macros.svh"

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = KEY_W + HANDLE_W;

   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(QUEUE_DEPTH);

   logic [EW-1:0] mem [QUEUE_DEPTH];

   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       walk_ff, walk_in;
   logic [EW-1:0]       rd_data_ff;
   logic [TIME_W-1:0]   new_time_ff;
   logic [ID_W-1:0]     new_id_ff;
   logic [HANDLE_W-1:0] new_handle_ff;
   status_code_type     code_ff;

   logic                rsp_tvalid_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_out_valid_ff;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_empty_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [AW:0]     tail_sum;
   logic [AW-1:0]   tail_addr;
   logic [AW-1:0]   walk_prev;
   logic [AW-1:0]   head_next;
   logic [KEY_W-1:0] rd_key;
   logic [CW-1:0]   count_dec;
   logic            full;
   logic            rsp_free;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign count_dec = count_ff - CW'(1);
   assign rsp_free  = !rsp_tvalid_ff || rsp_tready;

   // first free slot behind the last entry, modulo the depth
   assign tail_sum  = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign tail_addr = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);
   assign walk_prev = (walk_ff == '0) ? LAST_ADDR : walk_ff - AW'(1);
   assign head_next = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
   assign rd_key    = rd_data_ff[EW-1:HANDLE_W];

   assign stat.req_deq    = (req_op == OP_DEQ);
   assign stat.count_zero = (count_ff == '0);
   assign stat.full       = full;
   assign stat.at_head    = (walk_ff == head_ff);
   assign stat.key_ge     = (rd_key >= {new_time_ff, new_id_ff});
   assign stat.rsp_free   = rsp_free;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      walk_in  = walk_ff;
      if (cmd.load) begin
         walk_in = tail_addr;
      end
      if (cmd.shift_wr) begin
         walk_in = walk_prev;
      end
      if (cmd.ins_wr) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop) begin
         head_in  = head_next;
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (cmd.load) begin
         new_time_ff   <= req_time;
         new_id_ff     <= req_id;
         new_handle_ff <= req_handle;
         if (req_op == OP_DEQ) begin
            code_ff <= (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
         end else begin
            code_ff <= full ? STATUS_FULL : STATUS_DONE;
         end
      end
   end

   // entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.shift_wr) begin
         mem[walk_ff] <= rd_data_ff;
      end else if (cmd.ins_wr) begin
         mem[walk_ff] <= {new_time_ff, new_id_ff, new_handle_ff};
      end
      if (cmd.rd_prev) begin
         rd_data_ff <= mem[walk_prev];
      end else if (cmd.rd_head) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.pop || cmd.rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rsp_status_ff    <= STATUS_DONE;
         rsp_out_valid_ff <= 1'b1;
         rsp_time_ff      <= rd_data_ff[EW-1:ID_W+HANDLE_W];
         rsp_id_ff        <= rd_data_ff[ID_W+HANDLE_W-1:HANDLE_W];
         rsp_handle_ff    <= rd_data_ff[HANDLE_W-1:0];
         rsp_empty_ff     <= (count_dec == '0);
         rsp_count_ff     <= COUNT_W'(count_dec);
      end else if (cmd.rsp_load) begin
         rsp_status_ff    <= code_ff;
         rsp_out_valid_ff <= 1'b0;
         rsp_time_ff      <= '0;
         rsp_id_ff        <= '0;
         rsp_handle_ff    <= '0;
         rsp_empty_ff     <= (count_ff == '0);
         rsp_count_ff     <= COUNT_W'(count_ff);
      end
   end

   assign rsp_tvalid    = rsp_tvalid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_time      = rsp_time_ff;
   assign rsp_id        = rsp_id_ff;
   assign rsp_handle    = rsp_handle_ff;
   assign rsp_empty     = rsp_empty_ff;
   assign rsp_count     = rsp_count_ff;

   `TOEPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "count above depth")
   `TOEPQ_ASSERT(a_pop_nonempty, clock, reset, cmd.pop |-> count_ff != '0, "pop on empty store")
   `TOEPQ_ASSERT(a_ins_not_full, clock, reset, cmd.ins_wr |-> !full, "insert into full store")
   `TOEPQ_ASSERT(a_shift_below_head, clock, reset, cmd.shift_wr |-> walk_ff != head_ff, "shift past front")
   `TOEPQ_ASSERT(a_post_when_free, clock, reset, (cmd.pop || cmd.rsp_load) |-> rsp_free, "response overwritten")

endmodule

/* hw/rtl/time_ordered_event_priority_queue_unit.sv */
// Time-ordered event queue: entries sorted by (time, id), front first.
// req channel: tuser carries the op (0 enqueue, 1 dequeue); tdata carries the
// time, id and handle of an enqueue and is ignored for a dequeue.
// rsp channel: exactly one word per request, in request order, carrying the
// status, the dequeued entry (zeros if none), the empty flag and the count.
// Entries sit in a circular RAM with one write and one registered read port.
// A dequeue reads the front slot, then advances the head as it posts the
// response. An enqueue walks down from the tail, moving each entry whose key
// is not below the new one up a slot with a read and then a write on the RAM
// port, and writes the new entry into the slot where the walk stops.
// A refused enqueue or a dequeue on empty posts its response without RAM access.
// One request is in work at a time; req_tready is high only between requests,
// so the next request can be taken in the cycle after the response is posted.
// The response register holds while rsp_tready is low; the next request is
// still taken and runs up to its response, then waits for the slot.
// Synchronous reset empties the queue at once (count and head cleared) and
// drops a pending response; RAM contents are not cleared.
module time_ordered_event_priority_queue_unit
   import toepq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] op
   input  logic [63:0] req_tdata,   // [31:0] event_time, [47:32] event_id, [63:48] entry_handle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] out_valid
   output logic [71:0] rsp_tdata    // [31:0] out_time, [47:32] out_id, [63:48] out_handle,
                                    // [64] now_empty, [69:65] entry_count, [71:70] zero
);

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic [1:0]          rsp_status;
   logic                rsp_out_valid;
   logic [TIME_W-1:0]   rsp_time;
   logic [ID_W-1:0]     rsp_id;
   logic [HANDLE_W-1:0] rsp_handle;
   logic                rsp_empty;
   logic [COUNT_W-1:0]  rsp_count;

   toepq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   toepq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_tuser),
      .req_time      (req_tdata[31:0]),
      .req_id        (req_tdata[47:32]),
      .req_handle    (req_tdata[63:48]),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_out_valid (rsp_out_valid),
      .rsp_time      (rsp_time),
      .rsp_id        (rsp_id),
      .rsp_handle    (rsp_handle),
      .rsp_empty     (rsp_empty),
      .rsp_count     (rsp_count)
   );

   assign rsp_tuser = {rsp_out_valid, rsp_status};
   assign rsp_tdata = {2'b00, rsp_count, rsp_empty, rsp_handle, rsp_id, rsp_time};

endmodule

/* tb/event_order_monitor.sv */
module event_order_monitor
   import toepq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,     // [0] op
   input  logic [63:0] req_tdata,     // [31:0] event_time, [47:32] event_id, [63:48] entry_handle
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,     // [1:0] status, [2] out_valid
   input  logic [71:0] rsp_tdata,     // [31:0] out_time, [47:32] out_id, [63:48] out_handle,
                                      // [64] now_empty, [69:65] entry_count, [71:70] zero
   output int          failures,
   output int          pending,
   output int          popped,
   output int          refused_full,
   output int          empty_dequeues,
   output int          peak_fill
);

   typedef struct packed {
      logic [TIME_W-1:0]   t;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] h;
   } event_entry_type;

   typedef struct {
      status_code_type      status;
      logic                 got_entry;
      event_entry_type      entry;
      logic                 empty;
      logic [COUNT_W-1:0]   count;
   } queue_reply_type;

   event_entry_type sorted_entries[DEPTH];
   int              held;
   queue_reply_type reply_q[$];
   int              mismatches;

   assign failures = mismatches;

   // Apply one request to the sorted list and return the word it must produce.
   function automatic queue_reply_type apply_request(input logic op, input logic [63:0] data);
      queue_reply_type r;
      event_entry_type e;
      int              pos;
      r.status    = STATUS_DONE;
      r.got_entry = 1'b0;
      r.entry     = '0;
      e.t  = data[31:0];
      e.id = data[47:32];
      e.h  = data[63:48];
      if (op == OP_ENQ) begin
         if (held >= DEPTH) begin
            r.status = STATUS_FULL;
            refused_full++;
         end else begin
            // equal keys stop the walk, so the newest of a tie lands in front
            pos = 0;
            while (pos < held && {sorted_entries[pos].t, sorted_entries[pos].id} < {e.t, e.id})
               pos++;
            for (int i = held; i > pos; i--)
               sorted_entries[i] = sorted_entries[i-1];
            sorted_entries[pos] = e;
            held++;
            if (held > peak_fill)
               peak_fill = held;
         end
      end else if (held == 0) begin
         r.status = STATUS_EMPTY;
         empty_dequeues++;
      end else begin
         r.got_entry = 1'b1;
         r.entry     = sorted_entries[0];
         for (int i = 1; i < held; i++)
            sorted_entries[i-1] = sorted_entries[i];
         held--;
         popped++;
      end
      r.empty = (held == 0);
      r.count = COUNT_W'(held);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         held = 0;
         reply_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got tuser 0x%0h tdata 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = reply_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_tuser[1:0]));
               check_field("out_valid", 64'(want.got_entry), 64'(rsp_tuser[2]));
               check_field("out_time", 64'(want.entry.t), 64'(rsp_tdata[31:0]));
               check_field("out_id", 64'(want.entry.id), 64'(rsp_tdata[47:32]));
               check_field("out_handle", 64'(want.entry.h), 64'(rsp_tdata[63:48]));
               check_field("now_empty", 64'(want.empty), 64'(rsp_tdata[64]));
               check_field("entry_count", 64'(want.count), 64'(rsp_tdata[69:65]));
            end
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(apply_request(req_tuser, req_tdata));
      end
      pending <= reply_q.size();
   end

endmodule

/* tb/testbench.sv */
module testbench;
   import toepq_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 1600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 2 * DEPTH + 10;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED, PHASE_TIES} phase_kind_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tuser  = OP_ENQ;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [2:0]  rsp_tuser;
   logic [71:0] rsp_tdata;

   int failures, pending, popped, refused_full, empty_dequeues, peak_fill;
   int cycles     = 0;
   int burst_left = 0;
   int enq_sent   = 0;
   int deq_sent   = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   time_ordered_event_priority_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   event_order_monitor #(.DEPTH(DEPTH)) order_mon (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tuser      (rsp_tuser),
      .rsp_tdata      (rsp_tdata),
      .failures       (failures),
      .pending        (pending),
      .popped         (popped),
      .refused_full   (refused_full),
      .empty_dequeues (empty_dequeues),
      .peak_fill      (peak_fill)
   );

   // Receiver: switch between always ready, coin flips and sparse acceptance.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(READY_ALWAYS, READY_SPARSE));
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         default:      rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding", cycles, pending);
         $display("Some tests failed");
         $finish;
      end
   end

   // Hold the word until taken, then close the burst with a gap if it is used up.
   task automatic post_word(input logic op, input logic [31:0] t, input logic [15:0] id,
                            input logic [15:0] h);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {h, id, t};
      do @(posedge clock); while (!req_tready);
      if (op == OP_ENQ)
         enq_sent++;
      else
         deq_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
   endtask

   // Dequeue ignores tdata; fill it with noise anyway.
   task automatic post_dequeue();
      post_word(OP_DEQ, $urandom(), 16'($urandom()), 16'($urandom()));
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [31:0] pick_time(input bit crowded);
      if (crowded)
         return $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 15);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_id(input bit crowded);
      if (crowded)
         return 16'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 7));
         1:       return 16'hFFFF - 16'($urandom_range(0, 7));
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      int             sent;
      int             span;
      int             enq_pct;
      phase_kind_type phase;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      post_dequeue();
      // extremes of every field, plus ties on time and on (time, id)
      post_word(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      post_word(OP_ENQ, 32'h0000_0000, 16'h0000, 16'h0000);
      post_word(OP_ENQ, 32'h0000_0000, 16'hFFFF, 16'h0001);
      post_word(OP_ENQ, 32'hFFFF_FFFF, 16'h0000, 16'h0002);
      post_word(OP_ENQ, 32'd5, 16'd7, 16'd10);
      post_word(OP_ENQ, 32'd5, 16'd7, 16'd11);
      post_word(OP_ENQ, 32'd5, 16'd7, 16'd12);
      post_word(OP_ENQ, 32'd5, 16'd3, 16'd13);
      post_word(OP_ENQ, 32'd5, 16'd9, 16'd14);
      post_word(OP_ENQ, 32'd4, 16'd7, 16'd15);
      post_word(OP_ENQ, 32'd6, 16'd7, 16'd16);
      post_word(OP_ENQ, 32'h0000_0000, 16'h0000, 16'd17);
      post_word(OP_ENQ, 32'h8000_0000, 16'h8000, 16'h5555);
      post_word(OP_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 16'hAAAA);
      post_word(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 16'd18);
      post_word(OP_ENQ, 32'd1, 16'd1, 16'd19);
      // store is full here: this one must be refused
      post_word(OP_ENQ, 32'd3, 16'd3, 16'd20);
      repeat (7) post_dequeue();
      hold_until_drained();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         phase = phase_kind_type'($urandom_range(PHASE_FILL, PHASE_TIES));
         span  = $urandom_range(8, 48);
         case (phase)
            PHASE_FILL:  enq_pct = 85;
            PHASE_DRAIN: enq_pct = 15;
            PHASE_MIXED: enq_pct = 50;
            default:     enq_pct = 60;
         endcase
         for (int n = 0; n < span && sent < RANDOM_WORDS; n++) begin
            if ($urandom_range(1, 100) <= enq_pct)
               post_word(OP_ENQ, pick_time(phase == PHASE_TIES), pick_id(phase == PHASE_TIES),
                         16'($urandom()));
            else
               post_dequeue();
            sent++;
         end
         if ($urandom_range(0, 5) == 0)
            hold_until_drained();
      end

      hold_until_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Ran %0d enqueues and %0d dequeues, store peaked at %0d of %0d entries",
               enq_sent, deq_sent, peak_fill, DEPTH);
      $display("%0d entries came out in order, %0d refused on full, %0d dequeues on empty",
               popped, refused_full, empty_dequeues);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/toepq_pkg.sv
hw/rtl/toepq_ctrl.sv
hw/rtl/toepq_datapath.sv
hw/rtl/time_ordered_event_priority_queue_unit.sv
tb/event_order_monitor.sv
tb/testbench.sv
